// ===== rtl/necir_pkg.sv =====
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types and constants for the NEC IR edge decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

  // Input operation codes
  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Result frame kinds
  typedef enum logic [1:0] {
    KIND_NEC     = 2'd0,
    KIND_NEC_EXT = 2'd1,
    KIND_UNKNOWN = 2'd2
  } necir_kind_t;

  // Field widths
  localparam int TIME_W    = 32;
  localparam int TIMEOUT_W = 20;
  localparam int IDX_W     = 7;

  // Timeout register reset value (us)
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd20000;

  // Duration windows in microseconds
  localparam logic [31:0] LEAD_MARK_MIN  = 32'd7000;
  localparam logic [31:0] LEAD_MARK_MAX  = 32'd11000;
  localparam logic [31:0] LEAD_SPACE_MIN = 32'd3000;
  localparam logic [31:0] LEAD_SPACE_MAX = 32'd6000;
  localparam logic [31:0] BIT_MARK_MIN   = 32'd300;
  localparam logic [31:0] BIT_MARK_MAX   = 32'd900;
  localparam logic [31:0] ONE_SPACE_LO   = 32'd1000;  // exclusive
  localparam logic [31:0] ONE_SPACE_HI   = 32'd2200;  // exclusive
  localparam logic [31:0] BIT_SPACE_MIN  = 32'd300;
  localparam logic [31:0] BIT_SPACE_MAX  = 32'd2800;

  // Frame shape: leader pair plus 32 mark/space pairs
  localparam logic [IDX_W-1:0] LAST_DUR_IDX = 7'd65;
  localparam logic [IDX_W-1:0] REPORT_MIN   = 7'd4;

  // Address byte XOR inverse byte for standard NEC
  localparam logic [7:0] ADDR_CHECK = 8'hFF;

  // Word moving down the pipeline: clear flag plus a 32-bit value
  typedef struct packed {
    logic        clr;
    logic [31:0] val;
  } necir_item_t;

endpackage

// ===== rtl/necir_if.sv =====
// ----------------------------------------------------------------------------
// necir_if
// Valid/ready channels for edge words in and frame words out.
// ----------------------------------------------------------------------------
interface necir_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] edge_time;

  modport source (output valid, output opcode, output edge_time, input ready);
  modport sink   (input valid, input opcode, input edge_time, output ready);
endinterface

interface necir_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_kind;
  logic [15:0] address;
  logic [7:0]  command;
  logic [31:0] good_frames;
  logic [31:0] bad_frames;

  modport source (output valid, output frame_kind, output address, output command,
                  output good_frames, output bad_frames, input ready);
  modport sink   (input valid, input frame_kind, input address, input command,
                  input good_frames, input bad_frames, output ready);
endinterface

// ===== rtl/necir_div.sv =====
// ----------------------------------------------------------------------------
// necir_div
// Pipelined tick-to-microsecond conversion by reciprocal multiply and correction.
// ----------------------------------------------------------------------------
module necir_div #(
  parameter int TICKS_PER_US = 240
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_valid,
  output logic                  s_ready,
  input  necir_pkg::necir_item_t s_item,
  output logic                  m_valid,
  input  logic                  m_ready,
  output necir_pkg::necir_item_t m_item
);

  localparam int          DW      = $clog2(TICKS_PER_US + 1);
  localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / TICKS_PER_US);
  localparam logic [DW-1:0] DIVISOR = DW'(TICKS_PER_US);

  // stage valids and per-stage ready
  logic a_v, b_v, c_v, d_v;
  logic rd_a, rd_b, rd_c, rd_d;

  // stage payloads
  necir_pkg::necir_item_t a_item;
  logic        b_clr, c_clr;
  logic [31:0] b_x, c_x;
  logic [31:0] b_q, c_q;
  logic [31:0] c_qd;
  necir_pkg::necir_item_t d_item;

  logic [64:0]    prod;
  logic [31+DW:0] qd_full;
  logic [31:0]    rem;
  logic           corr;

  assign rd_d    = !d_v || m_ready;
  assign rd_c    = !c_v || rd_d;
  assign rd_b    = !b_v || rd_c;
  assign rd_a    = !a_v || rd_b;
  assign s_ready = rd_a;

  // estimate: q or q-1
  assign prod    = 65'(a_item.val) * 65'(RECIP);
  // back-multiply for the remainder
  assign qd_full = (32 + DW)'(b_q) * (32 + DW)'(DIVISOR);
  // one-step correction
  assign rem     = c_x - c_qd;
  assign corr    = (rem >= 32'(DIVISOR));

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else begin
      if (rd_a) a_v <= s_valid;
      if (rd_b) b_v <= a_v;
      if (rd_c) c_v <= b_v;
      if (rd_d) d_v <= c_v;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rd_a && s_valid) a_item <= s_item;
    if (rd_b && a_v) begin
      b_clr <= a_item.clr;
      b_x   <= a_item.val;
      b_q   <= prod[63:32];
    end
    if (rd_c && b_v) begin
      c_clr <= b_clr;
      c_x   <= b_x;
      c_q   <= b_q;
      c_qd  <= qd_full[31:0];
    end
    if (rd_d && c_v) begin
      d_item.clr <= c_clr;
      d_item.val <= c_q + 32'(corr);
    end
  end

  assign m_valid = d_v;
  assign m_item  = d_item;

endmodule

// ===== rtl/necir_frame.sv =====
// ----------------------------------------------------------------------------
// necir_frame
// NEC frame checker: duration windows, bit shifter, counters, result register.
// ----------------------------------------------------------------------------
module necir_frame (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [19:0]            cfg_wr_data,
  input  logic                   s_valid,
  output logic                   s_ready,
  input  necir_pkg::necir_item_t s_item,
  necir_out_if.source            frames
);

  // timeout register
  logic [necir_pkg::TIMEOUT_W-1:0] gap_timeout_us;

  // frame state
  logic [necir_pkg::IDX_W-1:0] duration_index, duration_index_next;
  logic [31:0] bit_shift, bit_shift_next;
  logic        await_gap, await_gap_next;
  logic [31:0] good_count, good_count_next;
  logic [31:0] bad_count, bad_count_next;

  // result register
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [15:0] res_addr;
  logic [7:0]  res_cmd;

  logic        take;
  logic        emit;
  logic [1:0]  emit_kind;
  logic [15:0] emit_addr;
  logic [7:0]  emit_cmd;

  logic [31:0] dur;
  logic        is_gap;
  logic        win_ok;
  logic        is_one;
  logic [31:0] shifted;

  assign s_ready = !res_valid || frames.ready;
  assign take    = s_valid && s_ready;
  assign dur     = s_item.val;
  assign is_gap  = dur > 32'(gap_timeout_us);
  assign is_one  = (dur > necir_pkg::ONE_SPACE_LO) && (dur < necir_pkg::ONE_SPACE_HI);
  assign shifted = {is_one, bit_shift[31:1]};

  // window check for the current position
  always_comb begin
    if (duration_index == '0) begin
      win_ok = (dur >= necir_pkg::LEAD_MARK_MIN) && (dur <= necir_pkg::LEAD_MARK_MAX);
    end else if (duration_index == necir_pkg::IDX_W'(1)) begin
      win_ok = (dur >= necir_pkg::LEAD_SPACE_MIN) && (dur <= necir_pkg::LEAD_SPACE_MAX);
    end else if (!duration_index[0]) begin
      win_ok = (dur >= necir_pkg::BIT_MARK_MIN) && (dur <= necir_pkg::BIT_MARK_MAX);
    end else begin
      win_ok = is_one ||
               ((dur >= necir_pkg::BIT_SPACE_MIN) && (dur <= necir_pkg::BIT_SPACE_MAX));
    end
  end

  // next frame state and result
  always_comb begin
    duration_index_next = duration_index;
    bit_shift_next      = bit_shift;
    await_gap_next      = await_gap;
    good_count_next     = good_count;
    bad_count_next      = bad_count;
    emit                = 1'b0;
    emit_kind           = necir_pkg::KIND_UNKNOWN;
    emit_addr           = '0;
    emit_cmd            = '0;
    if (s_item.clr) begin
      good_count_next = '0;
      bad_count_next  = '0;
    end else if (is_gap) begin
      // silence: close any partial frame
      duration_index_next = '0;
      bit_shift_next      = '0;
      await_gap_next      = 1'b0;
      if (!await_gap && (duration_index >= necir_pkg::REPORT_MIN)) begin
        bad_count_next = bad_count + 32'd1;
        emit           = 1'b1;
      end
    end else if (!await_gap) begin
      if (!win_ok) begin
        bad_count_next      = bad_count + 32'd1;
        duration_index_next = '0;
        bit_shift_next      = '0;
        await_gap_next      = 1'b1;
        emit                = 1'b1;
      end else begin
        if (duration_index[0] && (duration_index != necir_pkg::IDX_W'(1))) begin
          bit_shift_next = shifted;
        end
        duration_index_next = duration_index + necir_pkg::IDX_W'(1);
        if (duration_index == necir_pkg::LAST_DUR_IDX) begin
          // 32nd bit in: decode
          good_count_next     = good_count + 32'd1;
          duration_index_next = '0;
          bit_shift_next      = '0;
          await_gap_next      = 1'b1;
          emit                = 1'b1;
          emit_cmd            = shifted[23:16];
          if ((shifted[7:0] ^ shifted[15:8]) == necir_pkg::ADDR_CHECK) begin
            emit_kind = necir_pkg::KIND_NEC;
            emit_addr = {8'd0, shifted[7:0]};
          end else begin
            emit_kind = necir_pkg::KIND_NEC_EXT;
            emit_addr = shifted[15:0];
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_timeout_us <= necir_pkg::TIMEOUT_RESET;
      duration_index <= '0;
      bit_shift      <= '0;
      await_gap      <= 1'b0;
      good_count     <= '0;
      bad_count      <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) gap_timeout_us <= cfg_wr_data;
      if (take) begin
        duration_index <= duration_index_next;
        bit_shift      <= bit_shift_next;
        await_gap      <= await_gap_next;
        good_count     <= good_count_next;
        bad_count      <= bad_count_next;
        res_valid      <= emit;
      end else if (frames.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_kind <= emit_kind;
      res_addr <= emit_addr;
      res_cmd  <= emit_cmd;
    end
  end

  // counters are shown as they stood when the word was made
  logic [31:0] res_good, res_bad;
  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_good <= good_count_next;
      res_bad  <= bad_count_next;
    end
  end

  assign frames.valid       = res_valid;
  assign frames.frame_kind  = res_kind;
  assign frames.address     = res_addr;
  assign frames.command     = res_cmd;
  assign frames.good_frames = res_good;
  assign frames.bad_frames  = res_bad;

endmodule

// ===== rtl/nec_ir_edge_decoder.sv =====
// ----------------------------------------------------------------------------
// nec_ir_edge_decoder
// NEC IR decoder fed with captured edge timestamps in timer ticks.
// ----------------------------------------------------------------------------
// Takes one edge word per clock (opcode 0: edge timestamp, opcode 1: clear the
// frame counters) and returns a frame word after each decoded NEC or extended
// NEC frame, each failed check and each partial frame of four or more
// durations closed by a silence longer than gap_timeout_us. A word that makes
// a result passes the input register, the reciprocal multiply, back-multiply
// and correction registers that turn the tick difference into microseconds,
// and the frame check's result register. Edges stream in at one per cycle;
// only a stalled output holds the pipeline, and even then up to four further
// words are taken before the input stalls. The user writes gap_timeout_us
// through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module nec_ir_edge_decoder #(
  parameter int TICKS_PER_US = 240
) (
  input  logic        clk,
  input  logic        rst,
  necir_in_if.sink    edges,
  necir_out_if.source frames,
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_wr_data
);

  logic [31:0] last_edge_time;
  logic        edge_seen;

  logic                   div_s_valid, div_s_ready;
  necir_pkg::necir_item_t div_s_item;
  logic                   div_m_valid, div_m_ready;
  necir_pkg::necir_item_t div_m_item;

  logic accept;

  assign edges.ready = div_s_ready;
  assign accept      = edges.valid && div_s_ready;

  // the first edge after reset only records its time
  assign div_s_valid    = edges.valid &&
                          ((edges.opcode == necir_pkg::OP_CLEAR) || edge_seen);
  assign div_s_item.clr = (edges.opcode == necir_pkg::OP_CLEAR);
  assign div_s_item.val = edges.edge_time - last_edge_time;

  // edge timestamp tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      edge_seen      <= 1'b0;
    end else if (accept && (edges.opcode == necir_pkg::OP_EDGE)) begin
      last_edge_time <= edges.edge_time;
      edge_seen      <= 1'b1;
    end
  end

  necir_div #(
    .TICKS_PER_US (TICKS_PER_US)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .s_valid (div_s_valid),
    .s_ready (div_s_ready),
    .s_item  (div_s_item),
    .m_valid (div_m_valid),
    .m_ready (div_m_ready),
    .m_item  (div_m_item)
  );

  necir_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_valid     (div_m_valid),
    .s_ready     (div_m_ready),
    .s_item      (div_m_item),
    .frames      (frames)
  );

endmodule

// ===== dv/necir_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_frame_checker
// Watches the edge and frame channels of the NEC IR edge decoder. It keeps
// its own copy of the decoder state, predicts the frame word that each
// accepted edge word causes, and compares every frame word taken from the
// block with the oldest prediction.
// ----------------------------------------------------------------------------
module necir_frame_checker #(
  parameter int TICKS_PER_US = 240
) (
  input  logic        clk,
  input  logic        rst,
  necir_in_if         edges,
  necir_out_if        frames,
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_wr_data,
  output int          error_count,
  output int          outstanding
);
  import necir_pkg::*;

  typedef struct packed {
    necir_kind_t kind;
    logic [15:0] address;
    logic [7:0]  command;
    logic [31:0] good;
    logic [31:0] bad;
  } frame_word_t;

  // Predicted decoder state
  logic [TIMEOUT_W-1:0] gap_limit;
  logic [TIME_W-1:0]    prev_stamp;
  logic                 have_stamp;
  logic [IDX_W-1:0]     dur_count;
  logic [31:0]          data_bits;
  logic                 skip_to_gap;
  logic [31:0]          good_total;
  logic [31:0]          bad_total;

  frame_word_t pending_frames[$];
  int          n_errors;

  // Queue a frame word carrying the current frame counts
  function automatic void queue_frame(necir_kind_t kind, logic [15:0] addr, logic [7:0] cmd);
    frame_word_t w;
    w.kind    = kind;
    w.address = addr;
    w.command = cmd;
    w.good    = good_total;
    w.bad     = bad_total;
    pending_frames.push_back(w);
  endfunction

  // One edge word through the decoder
  task automatic decode_edge(input logic op, input logic [31:0] stamp);
    logic [31:0] dur_us;
    logic        bad_dur;
    logic [7:0]  addr_lo;
    logic [7:0]  addr_cpl;
    if (op == OP_CLEAR) begin
      good_total = '0;
      bad_total  = '0;
      return;
    end
    // first edge only records the time
    if (!have_stamp) begin
      have_stamp = 1'b1;
      prev_stamp = stamp;
      dur_count  = '0;
      data_bits  = '0;
      return;
    end
    dur_us     = (stamp - prev_stamp) / TICKS_PER_US;
    prev_stamp = stamp;

    // silence closes the frame; a partial one of four or more is reported
    if (dur_us > {12'd0, gap_limit}) begin
      if (!skip_to_gap && dur_count >= REPORT_MIN) begin
        bad_total = bad_total + 1;
        queue_frame(KIND_UNKNOWN, '0, '0);
      end
      dur_count   = '0;
      data_bits   = '0;
      skip_to_gap = 1'b0;
      return;
    end
    if (skip_to_gap) return;

    // window check for the position in the frame
    bad_dur = 1'b0;
    if (dur_count == 0) begin
      bad_dur = dur_us < LEAD_MARK_MIN || dur_us > LEAD_MARK_MAX;
    end else if (dur_count == 1) begin
      bad_dur = dur_us < LEAD_SPACE_MIN || dur_us > LEAD_SPACE_MAX;
    end else if (!dur_count[0]) begin
      bad_dur = dur_us < BIT_MARK_MIN || dur_us > BIT_MARK_MAX;
    end else begin
      data_bits = data_bits >> 1;
      if (dur_us > ONE_SPACE_LO && dur_us < ONE_SPACE_HI) data_bits[31] = 1'b1;
      else bad_dur = dur_us < BIT_SPACE_MIN || dur_us > BIT_SPACE_MAX;
    end

    if (bad_dur) begin
      bad_total   = bad_total + 1;
      dur_count   = '0;
      data_bits   = '0;
      skip_to_gap = 1'b1;
      queue_frame(KIND_UNKNOWN, '0, '0);
      return;
    end

    if (dur_count != LAST_DUR_IDX) begin
      dur_count = dur_count + 7'd1;
      return;
    end

    // 32nd bit in: standard when the address inverse byte matches
    addr_lo    = data_bits[7:0];
    addr_cpl   = data_bits[15:8];
    good_total = good_total + 1;
    if ((addr_lo ^ addr_cpl) == ADDR_CHECK)
      queue_frame(KIND_NEC, {8'd0, addr_lo}, data_bits[23:16]);
    else
      queue_frame(KIND_NEC_EXT, data_bits[15:0], data_bits[23:16]);
    dur_count   = '0;
    data_bits   = '0;
    skip_to_gap = 1'b1;
  endtask

  // Compare, then predict; a frame word never leaves in the cycle its edge enters
  always @(posedge clk) begin
    frame_word_t got;
    frame_word_t want;
    if (rst) begin
      gap_limit   = TIMEOUT_RESET;
      prev_stamp  = '0;
      have_stamp  = 1'b0;
      dur_count   = '0;
      data_bits   = '0;
      skip_to_gap = 1'b0;
      good_total  = '0;
      bad_total   = '0;
      pending_frames.delete();
    end else begin
      if (cfg_wr_en) gap_limit = cfg_wr_data;

      if (frames.valid && frames.ready) begin
        got.kind    = necir_kind_t'(frames.frame_kind);
        got.address = frames.address;
        got.command = frames.command;
        got.good    = frames.good_frames;
        got.bad     = frames.bad_frames;
        if (pending_frames.size() == 0) begin
          n_errors++;
          $display("%0t: frame word with none expected: kind %0d addr %h cmd %h good %0d bad %0d",
                   $time, got.kind, got.address, got.command, got.good, got.bad);
        end else begin
          want = pending_frames.pop_front();
          if (got !== want) begin
            n_errors++;
            $display("%0t: frame word mismatch: expected kind %0d addr %h cmd %h good %0d bad %0d",
                     $time, want.kind, want.address, want.command, want.good, want.bad);
            $display("%0t:                      actual   kind %0d addr %h cmd %h good %0d bad %0d",
                     $time, got.kind, got.address, got.command, got.good, got.bad);
          end
        end
      end

      if (edges.valid && edges.ready) decode_edge(edges.opcode, edges.edge_time);
    end
    outstanding <= pending_frames.size();
    error_count <= n_errors;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives edge words into the NEC IR edge decoder: a short directed run over
// the leader windows, partial frames and the statistics clear, then phases of
// random well-formed, broken and truncated frames with noise, each phase under
// a chosen gap timeout and one of four idling patterns. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import necir_pkg::*;

  localparam int TICKS_PER_US = 240;
  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 8;    // five-stage pipeline plus margin
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 150;
  localparam int N_PHASES     = 7;

  // Markers in the directed plan
  localparam int unsigned GAP_MARK   = 32'hFFFF_FFFF;
  localparam int unsigned CLEAR_MARK = 32'hFFFF_FFFE;

  typedef enum logic [1:0] {
    FRAME_GOOD,
    FRAME_BROKEN,
    FRAME_SHORT
  } frame_shape_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [19:0] cfg_wr_data;

  necir_in_if  edges_if ();
  necir_out_if frames_if ();

  int          error_count;
  int          outstanding;
  int          items_sent;
  int          cycle_count;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          hold_requests;
  int          hold_served;
  int          hold_left;
  logic [31:0] edge_clock;
  int unsigned gap_limit;

  // Leader windows, partial frames and a clear, in microseconds
  int unsigned directed_us [25] = '{
    GAP_MARK, 6999, GAP_MARK, 7000, 2999, GAP_MARK, 11000, 6001, GAP_MARK,
    11001, GAP_MARK, 7000, 3000, 299, GAP_MARK, CLEAR_MARK,
    9000, 4500, 560, GAP_MARK, 9000, 4500, 560, 1690, GAP_MARK
  };

  nec_ir_edge_decoder #(.TICKS_PER_US(TICKS_PER_US)) DUT (
    .clk         (clk),
    .rst         (rst),
    .edges       (edges_if),
    .frames      (frames_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  necir_frame_checker #(.TICKS_PER_US(TICKS_PER_US)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .edges       (edges_if),
    .frames      (frames_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Frame receiver: random stalls, plus long hold-offs on request
  initial begin
    frames_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        frames_if.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        frames_if.ready <= 1'b0;
      end else begin
        frames_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // One edge word, with random idle cycles ahead of it
  task automatic put_word(input logic op, input logic [31:0] stamp, input bit counted);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      edges_if.valid <= 1'b0;
      @(posedge clk);
    end
    edges_if.valid     <= 1'b1;
    edges_if.opcode    <= op;
    edges_if.edge_time <= stamp;
    @(posedge clk);
    while (!edges_if.ready) @(posedge clk);
    if (counted) items_sent++;
  endtask

  // Edge a whole number of microseconds after the last, with random sub-tick
  task automatic send_edge_us(input int unsigned us, input bit counted);
    edge_clock = edge_clock + us * TICKS_PER_US + $urandom_range(0, TICKS_PER_US - 1);
    put_word(OP_EDGE, edge_clock, counted);
  endtask

  task automatic send_gap();
    send_edge_us(gap_limit + 1 + $urandom_range(0, 2000), 1'b1);
  endtask

  // Value in a window, often one of its ends
  function automatic int unsigned pick_in(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Value just or well outside a window
  function automatic int unsigned outside(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 3))
      0: return lo - 1;
      1: return hi + 1;
      2: return $urandom_range(0, lo - 1);
      default: return $urandom_range(hi + 1, hi + 500);
    endcase
  endfunction

  function automatic int unsigned zero_space();
    if ($urandom_range(0, 1)) return pick_in(BIT_SPACE_MIN, ONE_SPACE_LO);
    return pick_in(ONE_SPACE_HI, BIT_SPACE_MAX);
  endfunction

  // Leader, up to 32 mark/space pairs, trailing edges unless short, and a closing gap
  task automatic send_frame(input frame_shape_t shape);
    logic [7:0]  adr;
    logic [7:0]  adr_inv;
    logic [7:0]  cmd;
    logic [7:0]  cmd_inv;
    logic [31:0] bits;
    int unsigned n_dur;
    int unsigned bad_at;
    int unsigned lo;
    int unsigned hi;
    int unsigned us;
    adr     = 8'($urandom());
    cmd     = 8'($urandom());
    adr_inv = $urandom_range(0, 1) ? ~adr : 8'($urandom());
    cmd_inv = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : ~cmd;
    bits    = {cmd_inv, cmd, adr_inv, adr};
    n_dur   = (shape == FRAME_SHORT) ? $urandom_range(1, 65) : 66;
    bad_at  = (shape == FRAME_BROKEN) ? $urandom_range(0, 65) : 66;
    for (int i = 0; i < n_dur && i <= bad_at; i++) begin
      if (i == 0) begin
        lo = LEAD_MARK_MIN;  hi = LEAD_MARK_MAX;
      end else if (i == 1) begin
        lo = LEAD_SPACE_MIN; hi = LEAD_SPACE_MAX;
      end else if (i % 2 == 0) begin
        lo = BIT_MARK_MIN;   hi = BIT_MARK_MAX;
      end else begin
        lo = BIT_SPACE_MIN;  hi = BIT_SPACE_MAX;
      end
      if (i == bad_at) us = outside(lo, hi);
      else if (i % 2 == 1 && i > 1)
        us = bits[(i - 3) / 2] ? pick_in(ONE_SPACE_LO + 1, ONE_SPACE_HI - 1) : zero_space();
      else us = pick_in(lo, hi);
      send_edge_us(us, 1'b1);
    end
    // stop mark or post-failure edges: ignored until the silence
    if (shape != FRAME_SHORT)
      repeat ($urandom_range(1, 3)) send_edge_us(pick_in(BIT_MARK_MIN, BIT_MARK_MAX), 1'b0);
    send_gap();
  endtask

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) send_frame(FRAME_GOOD);
    else if (pick < 75) send_frame(FRAME_BROKEN);
    else if (pick < 87) send_frame(FRAME_SHORT);
    else if (pick < 95) begin
      edge_clock = $urandom();
      put_word(OP_EDGE, edge_clock, 1'b1);
    end else put_word(OP_CLEAR, $urandom(), 1'b1);
  endtask

  // Sender stops and waits for every expected frame word
  task automatic wait_drained();
    edges_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_timeout(input int unsigned value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[19:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    gap_limit = value;
  endtask

  function automatic int unsigned timeout_for(int phase);
    case (phase)
      0: return 20000;
      1: return 1048575;
      2: return 1000000;
      3: return $urandom_range(12000, 60000);
      4: return 0;
      5: return 1;
      default: return 20000;
    endcase
  endfunction

  // Stimulus and verdict
  initial begin
    int phase_end;
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    edges_if.valid     <= 1'b0;
    edges_if.opcode    <= OP_EDGE;
    edges_if.edge_time <= '0;
    edge_clock = '0;
    gap_limit  = 32'(TIMEOUT_RESET);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first edge at the top of the timer, then a wrap to zero: 0 us leader
    edge_clock = 32'hFFFF_FFFF;
    put_word(OP_EDGE, edge_clock, 1'b1);
    edge_clock = '0;
    put_word(OP_EDGE, edge_clock, 1'b1);
    foreach (directed_us[i]) begin
      if (directed_us[i] == GAP_MARK) send_gap();
      else if (directed_us[i] == CLEAR_MARK) put_word(OP_CLEAR, $urandom(), 1'b1);
      else send_edge_us(directed_us[i], 1'b1);
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      write_timeout(timeout_for(phase));
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 75; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 75; end
        default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
      endcase

      // long receiver hold-off against a stream of failing leaders
      if (phase == 0) begin
        hold_requests++;
        repeat (12) begin
          send_edge_us(outside(LEAD_MARK_MIN, LEAD_MARK_MAX), 1'b1);
          send_gap();
        end
        wait_drained();
      end

      // running total, so whole frames that overshoot a phase are evened out
      phase_end = (phase + 1) * PHASE_ITEMS;
      while (items_sent < phase_end)
        random_item();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && outstanding == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
